### rtl/ktet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktet_pkg: shared types and constants of the keyed timer expiry table
// Cell count, request kinds, status codes, the entry and cell control structs and the states.
// ----------------------------------------------------------------------------
package ktet_pkg;

    localparam int ENTRIES = 64;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        KIND_SET    = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_EXIST  = 2'd2,
        KIND_TICK   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOTFOUND = 3'd1,
        ST_FULL     = 3'd2,
        ST_EXPIRED  = 3'd3,
        ST_NONE     = 3'd4
    } status_t;

    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] start;
        logic [31:0] gap;
        logic [31:0] expiry;
    } entry_t;

    // Operation broadcast to every cell in the same cycle.
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_REMOVE = 2'd1,   // cells at or above pos take their upper neighbour
        OP_INSERT = 2'd2    // cells at or above pos take lower neighbour / new
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        entry_t      new_entry;
        logic [31:0] key;
        logic [31:0] ins_exp;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REMOVE,
        S_INSERT,
        S_RESP,
        S_TICK
    } state_t;

endpackage

### rtl/keyed_timer_expiry_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_timer_expiry_table: sorted timer queue with keyed cancel and query
// A row of cells keeps up to ENTRIES timers in ascending expiry order.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_valid / s_ready  | kind, seq, now, gap
// m_      | out       | m_valid / m_ready  | status, seq_out, start_time,
//         |           |                    | gap_out, last
//
// A set holds the input through accept, remove, insert and respond before the
// next acceptance; cancel and query hold it through accept and respond. A
// tick drains one expired head per cycle while the output is taken.
// The key compare and the priority find across the cell row set the cycle
// length. Reset is synchronous, active low, and empties the row at once.
// A stalled output holds the result and the sequencer in place.
// ----------------------------------------------------------------------------
module keyed_timer_expiry_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [31:0] s_seq,
    input  logic [31:0] s_now,
    input  logic [31:0] s_gap,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_seq_out,
    output logic [31:0] m_start_time,
    output logic [31:0] m_gap_out,
    output logic        m_last
);
    import ktet_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    state_t      state_reg, state_next;
    logic [1:0]  kind_reg;
    logic [31:0] seq_reg, now_reg, gap_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    // Output register
    logic        m_valid_reg, m_valid_next;
    logic [2:0]  status_reg, status_next;
    logic [31:0] oseq_reg, oseq_next, ostart_reg, ostart_next, ogap_reg, ogap_next;
    logic        last_reg, last_next;

    // Set result status depends on S_INSERT: remember whether it was full
    logic set_full_reg;

    cell_ctl_t ctl;
    entry_t    ent  [ENTRIES];
    logic      vld  [ENTRIES];
    logic      hit  [ENTRIES];
    logic      aft  [ENTRIES];
    logic      shen [ENTRIES];
    logic      tnew [ENTRIES];

    // Find the lowest hit and the lowest later-expiry cell
    logic             hit_any, aft_any;
    logic [IDX_W-1:0] hit_pos, aft_pos, op_pos;
    entry_t           hit_entry;

    always_comb begin
        hit_any = 1'b0;
        hit_pos = '0;
        aft_any = 1'b0;
        aft_pos = IDX_W'(ENTRIES - 1);
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (hit[i]) begin
                hit_any = 1'b1;
                hit_pos = IDX_W'(i);
            end
            if (aft[i]) begin
                aft_any = 1'b1;
                aft_pos = IDX_W'(i);
            end
        end
        hit_entry = ent[hit_pos];
    end

    logic fire_in, out_free, full, head_exp;
    assign fire_in  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign full     = (count_reg == CNT_W'(ENTRIES));
    assign head_exp = vld[0] && (now_reg > ent[0].expiry);
    assign s_ready  = (state_reg == S_IDLE);

    // Cell control
    always_comb begin
        ctl.op        = OP_HOLD;
        ctl.key       = seq_reg;
        ctl.ins_exp   = now_reg + gap_reg;
        ctl.new_entry = '{seq: seq_reg, start: now_reg, gap: gap_reg,
                          expiry: now_reg + gap_reg};
        op_pos        = '0;
        unique case (state_reg)
            S_REMOVE: begin
                if (hit_any) begin
                    ctl.op = OP_REMOVE;
                end
                op_pos = hit_pos;
            end
            S_INSERT: begin
                if (!full) begin
                    ctl.op = OP_INSERT;
                end
                op_pos = aft_any ? aft_pos : IDX_W'(count_reg);
            end
            S_RESP: begin
                if (kind_reg == KIND_CANCEL && hit_any && out_free) begin
                    ctl.op = OP_REMOVE;
                end
                op_pos = hit_pos;
            end
            S_TICK: begin
                if (head_exp && out_free) begin
                    ctl.op = OP_REMOVE;
                end
            end
            default: begin
            end
        endcase
        for (int i = 0; i < ENTRIES; i++) begin
            shen[i] = (IDX_W'(i) >= op_pos);
            tnew[i] = (IDX_W'(i) == op_pos);
        end
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            entry_t le, ue;
            logic   lv, uv;
            if (g == 0) begin : g_lo
                assign le = '0;
                assign lv = 1'b0;
            end else begin : g_lo
                assign le = ent[g-1];
                assign lv = vld[g-1];
            end
            if (g == ENTRIES - 1) begin : g_hi
                assign ue = '0;
                assign uv = 1'b0;
            end else begin : g_hi
                assign ue = ent[g+1];
                assign uv = vld[g+1];
            end
            ktet_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctl         (ctl),
                .shift_en    (shen[g]),
                .take_new    (tnew[g]),
                .lower_entry (le),
                .lower_valid (lv),
                .upper_entry (ue),
                .upper_valid (uv),
                .entry       (ent[g]),
                .valid       (vld[g]),
                .key_hit     (hit[g]),
                .after_new   (aft[g])
            );
        end
    endgenerate

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (fire_in) begin
                    unique case (kind_t'(s_kind))
                        KIND_SET:  state_next = S_REMOVE;
                        KIND_TICK: state_next = S_TICK;
                        default:   state_next = S_RESP;
                    endcase
                end
            end
            S_REMOVE: state_next = S_INSERT;
            S_INSERT: state_next = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_TICK: begin
                if (out_free) begin
                    if (!head_exp || !(vld[1] && now_reg > ent[1].expiry)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs and count
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        oseq_next    = oseq_reg;
        ostart_next  = ostart_reg;
        ogap_next    = ogap_reg;
        last_next    = last_reg;
        count_next   = count_reg;
        if (ctl.op == OP_REMOVE) begin
            count_next = count_reg - CNT_W'(1);
        end else if (ctl.op == OP_INSERT) begin
            count_next = count_reg + CNT_W'(1);
        end
        if (state_reg == S_RESP && out_free) begin
            m_valid_next = 1'b1;
            last_next    = 1'b1;
            if (kind_reg == KIND_SET) begin
                status_next = set_full_reg ? ST_FULL : ST_OK;
                oseq_next   = seq_reg;
                ostart_next = now_reg;
                ogap_next   = gap_reg;
            end else if (hit_any) begin
                status_next = ST_OK;
                oseq_next   = hit_entry.seq;
                ostart_next = hit_entry.start;
                ogap_next   = hit_entry.gap;
            end else begin
                status_next = ST_NOTFOUND;
                oseq_next   = seq_reg;
                ostart_next = '0;
                ogap_next   = '0;
            end
        end
        if (state_reg == S_TICK && out_free) begin
            m_valid_next = 1'b1;
            if (head_exp) begin
                status_next = ST_EXPIRED;
                oseq_next   = ent[0].seq;
                ostart_next = ent[0].start;
                ogap_next   = ent[0].gap;
                last_next   = !(vld[1] && now_reg > ent[1].expiry);
            end else begin
                status_next = ST_NONE;
                oseq_next   = '0;
                ostart_next = '0;
                ogap_next   = '0;
                last_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire_in) begin
            kind_reg <= s_kind;
            seq_reg  <= s_seq;
            now_reg  <= s_now;
            gap_reg  <= s_gap;
        end
        if (state_reg == S_INSERT) begin
            set_full_reg <= full;
        end
        status_reg <= status_next;
        oseq_reg   <= oseq_next;
        ostart_reg <= ostart_next;
        ogap_reg   <= ogap_next;
        last_reg   <= last_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_seq_out    = oseq_reg;
    assign m_start_time = ostart_reg;
    assign m_gap_out    = ogap_reg;
    assign m_last       = last_reg;

endmodule

### rtl/ktet_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktet_cell: one slot of the sorted timer row
// Holds an entry and valid bit, compares against the key and new expiry,
// and shifts towards either neighbour on command.
// ----------------------------------------------------------------------------
module ktet_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  ktet_pkg::cell_ctl_t ctl,
    input  logic                shift_en,
    input  logic                take_new,
    input  ktet_pkg::entry_t    lower_entry,
    input  logic                lower_valid,
    input  ktet_pkg::entry_t    upper_entry,
    input  logic                upper_valid,
    output ktet_pkg::entry_t    entry,
    output logic                valid,
    output logic                key_hit,
    output logic                after_new
);
    import ktet_pkg::*;

    entry_t entry_reg, entry_next;
    logic   valid_reg, valid_next;

    assign entry     = entry_reg;
    assign valid     = valid_reg;
    assign key_hit   = valid_reg && (entry_reg.seq == ctl.key);
    // insertion goes before the first entry with a strictly later expiry
    assign after_new = valid_reg && (entry_reg.expiry > ctl.ins_exp);

    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (shift_en) begin
            unique case (ctl.op)
                OP_REMOVE: begin
                    entry_next = upper_entry;
                    valid_next = upper_valid;
                end
                OP_INSERT: begin
                    if (take_new) begin
                        entry_next = ctl.new_entry;
                    end else begin
                        entry_next = lower_entry;
                    end
                    valid_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
        if (!lower_valid && ctl.op == OP_INSERT && !take_new) begin
            valid_next = valid_reg;
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule
